// ===== design/vdsg_pkg.sv =====
// ---------------------------------------------------------------------------
// vdsg_pkg
// Types, stroke ROM and glyph table for the vector digit stroke generator.
// ---------------------------------------------------------------------------
package vdsg_pkg;

	localparam int GLYPH_COUNT  = 11;
	localparam int STROKE_COUNT = 86;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [5:0]  GLYPH_HEIGHT = 6'd48;
	localparam logic [5:0]  GLYPH_GAP    = 6'd8;
	localparam logic [15:0] PPU_RESET    = 16'd256;

	typedef enum logic [1:0] {
		OP_MOVE_ABS = 2'd0,
		OP_MOVE_REL = 2'd1,
		OP_DRAW     = 2'd2
	} stroke_op_t;

	typedef struct packed {
		stroke_op_t        op;
		logic signed [6:0] a;
		logic signed [6:0] b;
	} stroke_t;

	typedef struct packed {
		logic [6:0] first;
		logic [4:0] count;
		logic [5:0] width;
	} glyph_t;

	// One queued command from the front end
	typedef struct packed {
		logic               draw;
		logic               known;
		logic [3:0]         gidx;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic               first;
		logic               last;
	} cmd_t;

	localparam glyph_t GLYPHS [0:GLYPH_COUNT-1] = '{
		'{7'd0,  5'd2,  6'd16},
		'{7'd2,  5'd9,  6'd24},
		'{7'd11, 5'd3,  6'd12},
		'{7'd14, 5'd7,  6'd26},
		'{7'd21, 5'd13, 6'd24},
		'{7'd34, 5'd4,  6'd24},
		'{7'd38, 5'd9,  6'd28},
		'{7'd47, 5'd10, 6'd28},
		'{7'd57, 5'd3,  6'd24},
		'{7'd60, 5'd16, 6'd28},
		'{7'd76, 5'd10, 6'd28}
	};

	localparam stroke_t STROKES [0:STROKE_COUNT-1] = '{
		// '-'
		'{OP_MOVE_ABS, 7'sd0, 7'sd20}, '{OP_DRAW, 7'sd16, 7'sd0},
		// '0'
		'{OP_MOVE_ABS, 7'sd8, 7'sd0}, '{OP_DRAW, 7'sd8, 7'sd0},
		'{OP_DRAW, 7'sd8, 7'sd12}, '{OP_DRAW, 7'sd0, 7'sd24},
		'{OP_DRAW, -7'sd8, 7'sd12}, '{OP_DRAW, -7'sd8, 7'sd0},
		'{OP_DRAW, -7'sd8, -7'sd12}, '{OP_DRAW, 7'sd0, -7'sd24},
		'{OP_DRAW, 7'sd8, -7'sd12},
		// '1'
		'{OP_MOVE_ABS, 7'sd0, 7'sd8}, '{OP_DRAW, 7'sd8, -7'sd8},
		'{OP_DRAW, 7'sd0, 7'sd49},
		// '2'
		'{OP_MOVE_ABS, 7'sd0, 7'sd4}, '{OP_DRAW, 7'sd8, -7'sd4},
		'{OP_DRAW, 7'sd8, 7'sd0}, '{OP_DRAW, 7'sd8, 7'sd8},
		'{OP_DRAW, 7'sd0, 7'sd8}, '{OP_DRAW, -7'sd24, 7'sd32},
		'{OP_DRAW, 7'sd26, 7'sd0},
		// '3'
		'{OP_MOVE_ABS, 7'sd0, 7'sd4}, '{OP_DRAW, 7'sd8, -7'sd4},
		'{OP_DRAW, 7'sd8, 7'sd0}, '{OP_DRAW, 7'sd8, 7'sd8},
		'{OP_DRAW, 7'sd0, 7'sd8}, '{OP_DRAW, -7'sd8, 7'sd8},
		'{OP_MOVE_REL, -7'sd8, 7'sd0}, '{OP_DRAW, 7'sd8, 7'sd0},
		'{OP_DRAW, 7'sd8, 7'sd8}, '{OP_DRAW, 7'sd0, 7'sd8},
		'{OP_DRAW, -7'sd8, 7'sd8}, '{OP_DRAW, -7'sd8, 7'sd0},
		'{OP_DRAW, -7'sd8, -7'sd4},
		// '4'
		'{OP_MOVE_ABS, 7'sd24, 7'sd32}, '{OP_DRAW, -7'sd24, 7'sd0},
		'{OP_DRAW, 7'sd20, -7'sd32}, '{OP_DRAW, 7'sd0, 7'sd48},
		// '5'
		'{OP_MOVE_ABS, 7'sd28, 7'sd0}, '{OP_DRAW, -7'sd24, 7'sd0},
		'{OP_DRAW, -7'sd4, 7'sd20}, '{OP_DRAW, 7'sd20, 7'sd0},
		'{OP_DRAW, 7'sd8, 7'sd8}, '{OP_DRAW, 7'sd0, 7'sd12},
		'{OP_DRAW, -7'sd8, 7'sd8}, '{OP_DRAW, -7'sd12, 7'sd0},
		'{OP_DRAW, -7'sd8, -7'sd4},
		// '6'
		'{OP_MOVE_ABS, 7'sd24, 7'sd0}, '{OP_DRAW, -7'sd16, 7'sd0},
		'{OP_DRAW, -7'sd8, 7'sd12}, '{OP_DRAW, 7'sd0, 7'sd24},
		'{OP_DRAW, 7'sd8, 7'sd12}, '{OP_DRAW, 7'sd12, 7'sd0},
		'{OP_DRAW, 7'sd8, -7'sd8}, '{OP_DRAW, 7'sd0, -7'sd8},
		'{OP_DRAW, -7'sd8, -7'sd8}, '{OP_DRAW, -7'sd20, 7'sd0},
		// '7'
		'{OP_MOVE_ABS, 7'sd0, 7'sd0}, '{OP_DRAW, 7'sd24, 7'sd0},
		'{OP_DRAW, -7'sd20, 7'sd49},
		// '8'
		'{OP_MOVE_ABS, 7'sd8, 7'sd24}, '{OP_DRAW, -7'sd8, -7'sd6},
		'{OP_DRAW, 7'sd0, -7'sd12}, '{OP_DRAW, 7'sd8, -7'sd6},
		'{OP_DRAW, 7'sd12, 7'sd0}, '{OP_DRAW, 7'sd8, 7'sd6},
		'{OP_DRAW, 7'sd0, 7'sd12}, '{OP_DRAW, -7'sd8, 7'sd6},
		'{OP_DRAW, -7'sd12, 7'sd0}, '{OP_DRAW, -7'sd8, 7'sd6},
		'{OP_DRAW, 7'sd0, 7'sd12}, '{OP_DRAW, 7'sd8, 7'sd6},
		'{OP_DRAW, 7'sd12, 7'sd0}, '{OP_DRAW, 7'sd8, -7'sd6},
		'{OP_DRAW, 7'sd0, -7'sd12}, '{OP_DRAW, -7'sd8, -7'sd6},
		// '9'
		'{OP_MOVE_ABS, 7'sd28, 7'sd24}, '{OP_DRAW, -7'sd20, 7'sd0},
		'{OP_DRAW, -7'sd8, -7'sd8}, '{OP_DRAW, 7'sd0, -7'sd8},
		'{OP_DRAW, 7'sd8, -7'sd8}, '{OP_DRAW, 7'sd12, 7'sd0},
		'{OP_DRAW, 7'sd8, 7'sd12}, '{OP_DRAW, 7'sd0, 7'sd24},
		'{OP_DRAW, -7'sd8, 7'sd12}, '{OP_DRAW, -7'sd16, 7'sd0}
	};

endpackage

// ===== design/vdsg_ifs.sv =====
// ---------------------------------------------------------------------------
// vdsg channel interfaces
// Valid/ready channels for configuration, input characters and segments.
// ---------------------------------------------------------------------------
interface vdsg_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixels_per_unit_q8;

	modport source (output valid, output pixels_per_unit_q8, input ready);
	modport sink   (input valid, input pixels_per_unit_q8, output ready);
endinterface

interface vdsg_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [7:0]         char_code;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic               first_of_string;
	logic               last_of_string;

	modport source (output valid, output req_type, output char_code, output center_x,
		output center_y, output first_of_string, output last_of_string, input ready);
	modport sink   (input valid, input req_type, input char_code, input center_x,
		input center_y, input first_of_string, input last_of_string, output ready);
endinterface

interface vdsg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_start;
	logic signed [15:0] y_start;
	logic signed [15:0] x_end;
	logic signed [15:0] y_end;
	logic               last_segment;

	modport source (output valid, output x_start, output y_start, output x_end,
		output y_end, output last_segment, input ready);
	modport sink   (input valid, input x_start, input y_start, input x_end,
		input y_end, input last_segment, output ready);
endinterface

// ===== design/vdsg_front.sv =====
// ---------------------------------------------------------------------------
// vdsg_front
// Accepts characters, maps them to glyphs and queues the work commands.
// ---------------------------------------------------------------------------
module vdsg_front (
	vdsg_in_if.sink         chars,
	input  logic            q_full,
	output logic            push,
	output vdsg_pkg::cmd_t  cmd
);

	logic       known;
	logic [3:0] gidx;
	logic       keep;

	always_comb begin
		known = 1'b0;
		gidx  = '0;
		if (chars.char_code == vdsg_pkg::CHAR_MINUS) begin
			known = 1'b1;
		end else if (chars.char_code inside {[vdsg_pkg::CHAR_ZERO:vdsg_pkg::CHAR_NINE]}) begin
			known = 1'b1;
			gidx  = 4'(chars.char_code - vdsg_pkg::CHAR_ZERO) + 4'd1;
		end
	end

	// Drop items that leave no trace: unknown measures, unknown plain draws
	assign keep = known || (chars.req_type && (chars.first_of_string || chars.last_of_string));

	assign chars.ready = !q_full;
	assign push        = chars.valid && !q_full && keep;

	always_comb begin
		cmd.draw  = chars.req_type;
		cmd.known = known;
		cmd.gidx  = gidx;
		cmd.cx    = chars.center_x;
		cmd.cy    = chars.center_y;
		cmd.first = chars.first_of_string;
		cmd.last  = chars.last_of_string;
	end

endmodule

// ===== design/vdsg_queue.sv =====
// ---------------------------------------------------------------------------
// vdsg_queue
// Two-entry command queue between the front end and the segment engine.
// ---------------------------------------------------------------------------
module vdsg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vdsg_pkg::cmd_t  wr_data,
	input  logic            pop,
	output vdsg_pkg::cmd_t  rd_data,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = $clog2(vdsg_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(vdsg_pkg::QUEUE_DEPTH + 1);

	vdsg_pkg::cmd_t   mem_q [0:vdsg_pkg::QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(vdsg_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(vdsg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(vdsg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/vdsg_back.sv =====
// ---------------------------------------------------------------------------
// vdsg_back
// Segment engine: width sum, pen reference, stroke walk and output register.
// ---------------------------------------------------------------------------
module vdsg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     ppu,
	input  logic            q_empty,
	input  vdsg_pkg::cmd_t  q_data,
	output logic            pop,
	vdsg_out_if.source      segs
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_REF_MUL = 6'b000010,
		ST_REF_SUB = 6'b000100,
		ST_GLYPH   = 6'b001000,
		ST_ADV_MUL = 6'b010000,
		ST_ADV_ADD = 6'b100000
	} state_t;

	state_t             state_q;
	vdsg_pkg::cmd_t     cmd_q;
	logic [15:0]        sum_q;
	logic [15:0]        pen_x_q;
	logic [15:0]        pen_y_q;
	logic [24:0]        prod_x_q;
	logic [24:0]        prod_y_q;
	logic [21:0]        adv_prod_q;
	logic [6:0]         idx_q;
	logic [4:0]         cnt_q;
	logic signed [6:0]  ux_q;
	logic signed [6:0]  uy_q;
	logic               v_s1;
	logic               draw_s1;
	logic               last_s1;
	logic [15:0]        px_q;
	logic [15:0]        py_q;
	logic               out_v_q;
	logic signed [15:0] x_start_q;
	logic signed [15:0] y_start_q;
	logic signed [15:0] x_end_q;
	logic signed [15:0] y_end_q;
	logic               last_seg_q;

	vdsg_pkg::glyph_t   q_glyph;
	vdsg_pkg::glyph_t   cur_glyph;
	vdsg_pkg::stroke_t  stk;
	logic [31:0]        sum_prod;
	logic [24:0]        diff_x;
	logic [24:0]        diff_y;
	logic signed [23:0] pp;
	logic signed [23:0] mul_x;
	logic signed [23:0] mul_y;
	logic [23:0]        acc_x;
	logic [23:0]        acc_y;
	logic               out_free;
	logic               s1_go;
	logic               s0_go;
	logic [21:0]        adv_round;

	assign q_glyph   = vdsg_pkg::GLYPHS[q_data.gidx];
	assign cur_glyph = vdsg_pkg::GLYPHS[cmd_q.gidx];
	assign stk       = vdsg_pkg::STROKES[idx_q];

	assign pop = (state_q == ST_IDLE) && !q_empty;

	// Reference corner: floor(c - k * ppu / 2) with ppu in Q8
	assign sum_prod = sum_q * ppu;
	assign diff_x   = {cmd_q.cx, 9'd0} - prod_x_q;
	assign diff_y   = {cmd_q.cy, 9'd0} - prod_y_q;

	// Pixel of the current unit point: floor(ref + u * ppu + 1/2)
	assign pp    = {8'd0, ppu};
	assign mul_x = 24'(ux_q) * pp;
	assign mul_y = 24'(uy_q) * pp;
	assign acc_x = {pen_x_q, 8'd0} + 24'(mul_x) + 24'd128;
	assign acc_y = {pen_y_q, 8'd0} + 24'(mul_y) + 24'd128;

	assign out_free = !out_v_q || segs.ready;
	assign s1_go    = v_s1 && (!draw_s1 || out_free);
	assign s0_go    = (state_q == ST_GLYPH) && (cnt_q != '0) && (!v_s1 || s1_go);

	assign adv_round = adv_prod_q + 22'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (!q_data.draw) begin
							if (q_data.known) begin
								sum_q <= sum_q + 16'(q_glyph.width);
							end
						end else if (q_data.first) begin
							state_q <= ST_REF_MUL;
						end else if (q_data.known) begin
							state_q <= ST_GLYPH;
						end else begin
							state_q <= ST_ADV_ADD;
						end
					end
				end
				ST_REF_MUL: begin
					state_q <= ST_REF_SUB;
				end
				ST_REF_SUB: begin
					pen_x_q <= diff_x[24:9];
					pen_y_q <= diff_y[24:9];
					state_q <= cmd_q.known ? ST_GLYPH : ST_ADV_ADD;
				end
				ST_GLYPH: begin
					if (cnt_q == '0 && !v_s1) begin
						state_q <= ST_ADV_MUL;
					end
				end
				ST_ADV_MUL: begin
					state_q <= ST_ADV_ADD;
				end
				ST_ADV_ADD: begin
					if (cmd_q.known) begin
						pen_x_q <= pen_x_q + 16'(adv_round[21:8]);
					end
					if (cmd_q.last) begin
						sum_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath holding registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
		end
		if (state_q == ST_REF_MUL) begin
			prod_x_q <= sum_prod[24:0];
			prod_y_q <= 25'(ppu * 22'(vdsg_pkg::GLYPH_HEIGHT));
		end
		if (state_q == ST_ADV_MUL) begin
			adv_prod_q <= 22'(cur_glyph.width + vdsg_pkg::GLYPH_GAP) * 22'(ppu);
		end
		if (s0_go) begin
			if (stk.op == vdsg_pkg::OP_MOVE_ABS) begin
				ux_q <= stk.a;
				uy_q <= stk.b;
			end else begin
				ux_q <= ux_q + stk.a;
				uy_q <= uy_q + stk.b;
			end
		end
		if (s1_go) begin
			px_q <= acc_x[23:8];
			py_q <= acc_y[23:8];
		end
		if (s1_go && draw_s1) begin
			x_start_q  <= px_q;
			y_start_q  <= py_q;
			x_end_q    <= acc_x[23:8];
			y_end_q    <= acc_y[23:8];
			last_seg_q <= last_s1;
		end
	end

	// Stroke walk: stage 0 reads the ROM, stage 1 scales into pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			draw_s1 <= 1'b0;
			last_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				idx_q <= q_glyph.first;
				cnt_q <= q_glyph.count;
			end else if (s0_go) begin
				idx_q <= idx_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			if (s0_go) begin
				v_s1    <= 1'b1;
				draw_s1 <= (stk.op == vdsg_pkg::OP_DRAW);
				last_s1 <= (cnt_q == 5'd1);
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go && draw_s1) begin
				out_v_q <= 1'b1;
			end else if (segs.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign segs.valid        = out_v_q;
	assign segs.x_start      = x_start_q;
	assign segs.y_start      = y_start_q;
	assign segs.x_end        = x_end_q;
	assign segs.y_end        = y_end_q;
	assign segs.last_segment = last_seg_q;

endmodule

// ===== design/vector_digit_stroke_generator.sv =====
// ---------------------------------------------------------------------------
// vector_digit_stroke_generator
// Stroke-font generator for '-' and '0'..'9' with centered two-pass layout.
// A measure item adds the width of a known glyph to the running sum. A draw
// item walks the glyph's N strokes, where N is its stroke count (2 to 16):
// the stroke ROM is read once per cycle while the output is not stalled,
// and each stroke is scaled by a 7x16 multiply in the following stage. The
// first item of a string passes REF_MUL and REF_SUB to compute the reference
// corner, and ADV_MUL and ADV_ADD advance the pen. A two-entry queue lets
// the input side keep accepting while the engine works, and the segment
// output is registered so a stalled sink only holds the stroke walk.
// The scale register may be written only while the block is idle.
// ---------------------------------------------------------------------------
module vector_digit_stroke_generator (
	input  logic        clk,
	input  logic        arst_n,
	vdsg_cfg_if.sink    cfg,
	vdsg_in_if.sink     chars,
	vdsg_out_if.source  segs
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	vdsg_pkg::cmd_t push_cmd;
	vdsg_pkg::cmd_t head_cmd;
	logic [15:0]    ppu_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q <= vdsg_pkg::PPU_RESET;
		end else if (cfg.valid) begin
			ppu_q <= cfg.pixels_per_unit_q8;
		end
	end

	vdsg_front u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	vdsg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.pop     (pop),
		.rd_data (head_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	vdsg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ppu     (ppu_q),
		.q_empty (q_empty),
		.q_data  (head_cmd),
		.pop     (pop),
		.segs    (segs)
	);

endmodule

// ===== test/vector_digit_stroke_generator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_digit_stroke_generator_test
// Self-checking bench for the digit stroke generator. Strings of characters
// go in as measure and draw items over valid/ready channels. A local stroke
// font and scaler work out every segment expected on the output. Each segment
// is compared field by field in order. The scale register is swept over
// several values, including zero and both ends of its range.
// ---------------------------------------------------------------------------
module vector_digit_stroke_generator_test;

	typedef struct packed {
		logic               req_type;
		logic [7:0]         char_code;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic               first_of_string;
		logic               last_of_string;
	} char_item_t;

	typedef struct packed {
		logic signed [15:0] x_start;
		logic signed [15:0] y_start;
		logic signed [15:0] x_end;
		logic signed [15:0] y_end;
		logic               last_segment;
	} segment_t;

	// One directed step: a scale write, or an item with an optional
	// hand-computed first segment
	typedef struct packed {
		bit         is_cfg;
		logic [15:0] scale;
		char_item_t item;
		bit         typed;
		segment_t   want;
	} step_t;

	localparam int TEXT_HEIGHT   = 48;
	localparam int PEN_GAP       = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_BLOCKS = 6;
	localparam int BLOCK_ITEMS   = 47;

	// Stroke font: op, a, b per stroke
	localparam int FONT_STROKES [0:3*86-1] = '{
		vdsg_pkg::OP_MOVE_ABS, 0, 20, vdsg_pkg::OP_DRAW, 16, 0,
		vdsg_pkg::OP_MOVE_ABS, 8, 0, vdsg_pkg::OP_DRAW, 8, 0, vdsg_pkg::OP_DRAW, 8, 12,
		vdsg_pkg::OP_DRAW, 0, 24, vdsg_pkg::OP_DRAW, -8, 12, vdsg_pkg::OP_DRAW, -8, 0,
		vdsg_pkg::OP_DRAW, -8, -12, vdsg_pkg::OP_DRAW, 0, -24, vdsg_pkg::OP_DRAW, 8, -12,
		vdsg_pkg::OP_MOVE_ABS, 0, 8, vdsg_pkg::OP_DRAW, 8, -8, vdsg_pkg::OP_DRAW, 0, 49,
		vdsg_pkg::OP_MOVE_ABS, 0, 4, vdsg_pkg::OP_DRAW, 8, -4, vdsg_pkg::OP_DRAW, 8, 0,
		vdsg_pkg::OP_DRAW, 8, 8, vdsg_pkg::OP_DRAW, 0, 8, vdsg_pkg::OP_DRAW, -24, 32,
		vdsg_pkg::OP_DRAW, 26, 0,
		vdsg_pkg::OP_MOVE_ABS, 0, 4, vdsg_pkg::OP_DRAW, 8, -4, vdsg_pkg::OP_DRAW, 8, 0,
		vdsg_pkg::OP_DRAW, 8, 8, vdsg_pkg::OP_DRAW, 0, 8, vdsg_pkg::OP_DRAW, -8, 8,
		vdsg_pkg::OP_MOVE_REL, -8, 0, vdsg_pkg::OP_DRAW, 8, 0, vdsg_pkg::OP_DRAW, 8, 8,
		vdsg_pkg::OP_DRAW, 0, 8, vdsg_pkg::OP_DRAW, -8, 8, vdsg_pkg::OP_DRAW, -8, 0,
		vdsg_pkg::OP_DRAW, -8, -4,
		vdsg_pkg::OP_MOVE_ABS, 24, 32, vdsg_pkg::OP_DRAW, -24, 0,
		vdsg_pkg::OP_DRAW, 20, -32, vdsg_pkg::OP_DRAW, 0, 48,
		vdsg_pkg::OP_MOVE_ABS, 28, 0, vdsg_pkg::OP_DRAW, -24, 0, vdsg_pkg::OP_DRAW, -4, 20,
		vdsg_pkg::OP_DRAW, 20, 0, vdsg_pkg::OP_DRAW, 8, 8, vdsg_pkg::OP_DRAW, 0, 12,
		vdsg_pkg::OP_DRAW, -8, 8, vdsg_pkg::OP_DRAW, -12, 0, vdsg_pkg::OP_DRAW, -8, -4,
		vdsg_pkg::OP_MOVE_ABS, 24, 0, vdsg_pkg::OP_DRAW, -16, 0, vdsg_pkg::OP_DRAW, -8, 12,
		vdsg_pkg::OP_DRAW, 0, 24, vdsg_pkg::OP_DRAW, 8, 12, vdsg_pkg::OP_DRAW, 12, 0,
		vdsg_pkg::OP_DRAW, 8, -8, vdsg_pkg::OP_DRAW, 0, -8, vdsg_pkg::OP_DRAW, -8, -8,
		vdsg_pkg::OP_DRAW, -20, 0,
		vdsg_pkg::OP_MOVE_ABS, 0, 0, vdsg_pkg::OP_DRAW, 24, 0, vdsg_pkg::OP_DRAW, -20, 49,
		vdsg_pkg::OP_MOVE_ABS, 8, 24, vdsg_pkg::OP_DRAW, -8, -6, vdsg_pkg::OP_DRAW, 0, -12,
		vdsg_pkg::OP_DRAW, 8, -6, vdsg_pkg::OP_DRAW, 12, 0, vdsg_pkg::OP_DRAW, 8, 6,
		vdsg_pkg::OP_DRAW, 0, 12, vdsg_pkg::OP_DRAW, -8, 6, vdsg_pkg::OP_DRAW, -12, 0,
		vdsg_pkg::OP_DRAW, -8, 6, vdsg_pkg::OP_DRAW, 0, 12, vdsg_pkg::OP_DRAW, 8, 6,
		vdsg_pkg::OP_DRAW, 12, 0, vdsg_pkg::OP_DRAW, 8, -6, vdsg_pkg::OP_DRAW, 0, -12,
		vdsg_pkg::OP_DRAW, -8, -6,
		vdsg_pkg::OP_MOVE_ABS, 28, 24, vdsg_pkg::OP_DRAW, -20, 0, vdsg_pkg::OP_DRAW, -8, -8,
		vdsg_pkg::OP_DRAW, 0, -8, vdsg_pkg::OP_DRAW, 8, -8, vdsg_pkg::OP_DRAW, 12, 0,
		vdsg_pkg::OP_DRAW, 8, 12, vdsg_pkg::OP_DRAW, 0, 24, vdsg_pkg::OP_DRAW, -8, 12,
		vdsg_pkg::OP_DRAW, -16, 0
	};
	localparam int FONT_FIRST [0:10] = '{0, 2, 11, 14, 21, 34, 38, 47, 57, 60, 76};
	localparam int FONT_LEN   [0:10] = '{2, 9, 3, 7, 13, 4, 9, 10, 3, 16, 10};
	localparam int FONT_WIDTH [0:10] = '{16, 24, 12, 26, 24, 24, 28, 28, 24, 28, 28};

	localparam step_t DIRECTED [0:24] = '{
		'{0, 0, '{1, "-", 0, 0, 1, 1}, 1, '{0, -4, 16, -4, 1}},
		'{0, 0, '{0, "0", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{0, "-", 0, 0, 1, 0}, 0, '0},
		'{0, 0, '{0, "A", 0, 0, 1, 1}, 0, '0},
		'{0, 0, '{1, "0", 100, 50, 1, 0}, 1, '{88, 26, 96, 26, 0}},
		'{0, 0, '{1, "A", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "-", 0, 0, 0, 1}, 1, '{112, 46, 128, 46, 1}},
		'{0, 0, '{1, "1", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "2", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "3", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "4", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "5", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "6", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "7", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "8", 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, "9", 0, 0, 0, 0}, 0, '0},
		'{1, 0, '0, 0, '0},
		// zero scale: every point lands on the center
		'{0, 0, '{1, "8", -32768, 32767, 1, 1}, 1, '{-32768, 32767, -32768, 32767, 0}},
		'{1, 65535, '0, 0, '0},
		'{0, 0, '{0, "8", 0, 0, 1, 1}, 0, '0},
		'{0, 0, '{1, "8", 32767, -32768, 1, 1}, 0, '0},
		'{1, 1, '0, 0, '0},
		'{0, 0, '{0, 8'hFF, 0, 0, 0, 0}, 0, '0},
		'{0, 0, '{1, 8'h00, -1, -1, 1, 0}, 0, '0},
		'{0, 0, '{1, "7", 0, 0, 0, 1}, 0, '0}
	};

	logic clk;
	logic arst_n;

	vdsg_cfg_if cfg_bus();
	vdsg_in_if  char_bus();
	vdsg_out_if seg_bus();

	vector_digit_stroke_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.chars  (char_bus),
		.segs   (seg_bus)
	);

	// Predictor state
	logic [15:0]        scale_q8  = 16'd256;
	logic [15:0]        width_sum = '0;
	logic signed [15:0] pen_x     = '0;
	logic signed [15:0] pen_y     = '0;

	segment_t pending_segs[$];
	segment_t drawn_segs[$];
	int       mismatch_count = 0;
	int       items_sent     = 0;
	int       send_idle_pct  = 0;
	int       recv_idle_pct  = 0;
	int       hold_left      = 0;
	bit       hold_req       = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got),
				$signed(want)));
	endtask

	function automatic int glyph_of(input logic [7:0] c);
		if (c == vdsg_pkg::CHAR_MINUS)
			return 0;
		if (c >= vdsg_pkg::CHAR_ZERO && c <= vdsg_pkg::CHAR_NINE)
			return int'(c - vdsg_pkg::CHAR_ZERO) + 1;
		return -1;
	endfunction

	// floor(origin + units * scale + 1/2), wrapped to 16 bits
	function automatic logic [15:0] to_pixel(input longint origin, input longint units);
		return 16'((origin * 256 + units * longint'(scale_q8) + 128) >>> 8);
	endfunction

	// Walk the glyph's strokes into drawn_segs and update the pen state
	task automatic predict_strokes(input char_item_t it);
		int       g;
		int       k;
		longint   p;
		longint   rx;
		longint   ry;
		longint   ux;
		longint   uy;
		segment_t s;
		drawn_segs.delete();
		g = glyph_of(it.char_code);
		p = longint'(scale_q8);
		if (!it.req_type) begin
			if (g >= 0)
				width_sum = width_sum + 16'(FONT_WIDTH[g]);
			return;
		end
		if (it.first_of_string) begin
			pen_x = 16'((longint'(it.center_x) * 512 - longint'(width_sum) * p) >>> 9);
			pen_y = 16'((longint'(it.center_y) * 512 - TEXT_HEIGHT * p) >>> 9);
		end
		if (g >= 0) begin
			rx = pen_x;
			ry = pen_y;
			ux = 0;
			uy = 0;
			for (k = FONT_FIRST[g]; k < FONT_FIRST[g] + FONT_LEN[g]; k++) begin
				if (FONT_STROKES[3*k] == vdsg_pkg::OP_DRAW) begin
					s.x_start = to_pixel(rx, ux);
					s.y_start = to_pixel(ry, uy);
					ux += FONT_STROKES[3*k+1];
					uy += FONT_STROKES[3*k+2];
					s.x_end = to_pixel(rx, ux);
					s.y_end = to_pixel(ry, uy);
					s.last_segment = 1'b0;
					drawn_segs.push_back(s);
				end else if (FONT_STROKES[3*k] == vdsg_pkg::OP_MOVE_REL) begin
					ux += FONT_STROKES[3*k+1];
					uy += FONT_STROKES[3*k+2];
				end else begin
					ux = FONT_STROKES[3*k+1];
					uy = FONT_STROKES[3*k+2];
				end
			end
			if (drawn_segs.size() != 0)
				drawn_segs[drawn_segs.size()-1].last_segment = 1'b1;
			pen_x = 16'(rx + (((FONT_WIDTH[g] + PEN_GAP) * p + 128) >>> 8));
		end
		if (it.last_of_string)
			width_sum = '0;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input char_item_t it, input bit typed, input segment_t first_seg);
		while ($urandom_range(99) < send_idle_pct) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid           <= 1'b1;
		char_bus.req_type        <= it.req_type;
		char_bus.char_code       <= it.char_code;
		char_bus.center_x        <= it.center_x;
		char_bus.center_y        <= it.center_y;
		char_bus.first_of_string <= it.first_of_string;
		char_bus.last_of_string  <= it.last_of_string;
		@(posedge clk);
		while (char_bus.ready !== 1'b1)
			@(posedge clk);
		predict_strokes(it);
		if (typed && drawn_segs.size() != 0)
			drawn_segs[0] = first_seg;
		while (drawn_segs.size() != 0)
			pending_segs.push_back(drawn_segs.pop_front());
		items_sent++;
		@(negedge clk);
	endtask

	// Drain the block, then write the scale register
	task automatic set_scale(input logic [15:0] value);
		char_bus.valid <= 1'b0;
		while (pending_segs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_bus.valid              <= 1'b1;
		cfg_bus.pixels_per_unit_q8 <= value;
		@(posedge clk);
		while (cfg_bus.ready !== 1'b1)
			@(posedge clk);
		scale_q8 = value;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_glyph_char();
		int k;
		k = $urandom_range(0, 10);
		return (k == 0) ? vdsg_pkg::CHAR_MINUS : vdsg_pkg::CHAR_ZERO + 8'(k - 1);
	endfunction

	// Measure pass then draw pass over one string, sometimes malformed
	task automatic send_string(input bit squeeze);
		logic [7:0]         text[$];
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		int                 len;
		int                 i;
		bit                 skip_measure;
		bit                 drop_last;
		char_item_t         it;
		len = $urandom_range(1, 6);
		for (i = 0; i < len; i++)
			text.push_back(($urandom_range(99) < 88) ? pick_glyph_char()
				: 8'($urandom_range(0, 255)));
		skip_measure = ($urandom_range(99) < 8);
		drop_last    = ($urandom_range(99) < 8);
		cx = 16'($urandom);
		cy = 16'($urandom);
		if (!skip_measure) begin
			for (i = 0; i < len; i++) begin
				it = '{1'b0, text[i], 16'($urandom), 16'($urandom), 1'($urandom),
					1'($urandom)};
				send_item(it, 1'b0, '0);
			end
		end
		if (squeeze)
			hold_req = 1'b1;
		for (i = 0; i < len; i++) begin
			it = '{1'b1, text[i], cx, cy, i == 0, i == len - 1 && !drop_last};
			send_item(it, 1'b0, '0);
		end
	endtask

	function automatic logic [15:0] block_scale(input int blk);
		case (blk)
			0: return 16'd65535;
			1: return 16'd1;
			2: return 16'($urandom_range(128, 1024));
			3: return 16'($urandom_range(0, 65535));
			4: return 16'd256;
			default: return 16'($urandom_range(1, 4096));
		endcase
	endfunction

	initial begin : stimulus
		int         i;
		int         blk;
		int         budget;
		bit         squeezed;
		char_item_t it;
		squeezed                 = 1'b0;
		arst_n                   = 1'b0;
		cfg_bus.valid            = 1'b0;
		cfg_bus.pixels_per_unit_q8 = '0;
		char_bus.valid           = 1'b0;
		char_bus.req_type        = 1'b0;
		char_bus.char_code       = '0;
		char_bus.center_x        = '0;
		char_bus.center_y        = '0;
		char_bus.first_of_string = 1'b0;
		char_bus.last_of_string  = 1'b0;
		send_idle_pct = 37;
		recv_idle_pct = 87;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].is_cfg)
				set_scale(DIRECTED[i].scale);
			else
				send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			// swap idle ratios from block 2, then run flat out from block 4
			if (blk == 2) begin
				send_idle_pct = 87;
				recv_idle_pct = 37;
			end else if (blk == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_scale(block_scale(blk));
			budget = items_sent + BLOCK_ITEMS;
			while (items_sent < budget) begin
				if ($urandom_range(99) < 15 && !(blk == 4 && !squeezed)) begin
					it = '{1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
						1'($urandom), 1'($urandom)};
					send_item(it, 1'b0, '0);
				end else begin
					// in block 4, stall the output during the first draw pass
					send_string(blk == 4 && !squeezed);
					if (blk == 4)
						squeezed = 1'b1;
				end
			end
		end

		char_bus.valid <= 1'b0;
		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : sink_side
		seg_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				seg_bus.ready <= 1'b0;
			end else begin
				seg_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : segment_check
		segment_t want;
		if (arst_n && seg_bus.valid === 1'b1 && seg_bus.ready === 1'b1) begin
			if (pending_segs.size() == 0) begin
				report_mismatch("segment with nothing expected");
			end else begin
				want = pending_segs.pop_front();
				check_field("x_start", seg_bus.x_start, want.x_start);
				check_field("y_start", seg_bus.y_start, want.y_start);
				check_field("x_end", seg_bus.x_end, want.x_end);
				check_field("y_end", seg_bus.y_end, want.y_end);
				check_field("last_segment", 16'(seg_bus.last_segment),
					16'(want.last_segment));
			end
		end
	end

	initial begin : watchdog
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
